@@ rtl/fty_pkg.sv @@
// ----------------------------------------------------------------------------
// fty_pkg
// shared types and constants for the fader touch and yield detector
// ----------------------------------------------------------------------------
package fty_pkg;

    localparam int unsigned ADC_W    = 12;
    localparam int unsigned POS_W    = 12;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned RUN_W    = 8;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned DEB_W    = 16;
    localparam int unsigned CODE_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_LEVEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_SAMPLES = 3'd5;

    // register reset values
    localparam logic [ADC_W-1:0]  RST_TOUCH_LEVEL   = 12'd1000;
    localparam logic [ADC_W-1:0]  RST_CURRENT_LEVEL = 12'd300;
    localparam logic [MODE_W-1:0] RST_FEEDBACK_MODE = 2'd1;
    localparam logic [POS_W-1:0]  RST_MOVE_LEVEL    = 12'd82;
    localparam logic [DEB_W-1:0]  RST_DEBOUNCE_TIME = 16'd20;
    localparam logic [RUN_W-1:0]  RST_FORCE_SAMPLES = 8'd3;

    // feedback modes
    localparam logic [MODE_W-1:0] MODE_DISABLED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HOLD     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SPRING   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FOLLOW   = 2'd3;

    // phase codes as seen on the result
    localparam logic [CODE_W-1:0] CODE_IDLE     = 2'd0;
    localparam logic [CODE_W-1:0] CODE_TOUCHED  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_MOVING   = 2'd2;
    localparam logic [CODE_W-1:0] CODE_RELEASED = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_TOUCHED  = 4'b0010,
        PH_MOVING   = 4'b0100,
        PH_RELEASED = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [ADC_W-1:0]  touch_level;
        logic [ADC_W-1:0]  current_level;
        logic [MODE_W-1:0] feedback_mode;
        logic [POS_W-1:0]  move_level;
        logic [DEB_W-1:0]  debounce_time;
        logic [RUN_W-1:0]  force_samples;
    } cfg_t;

    typedef struct packed {
        logic [ADC_W-1:0]  touch_sample;
        logic [ADC_W-1:0]  current_sample;
        logic [POS_W-1:0]  fader_pos;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        phase_t            phase;
        logic [RUN_W-1:0]  high_run;
        logic [POS_W-1:0]  prev_pos;
        logic [POS_W-1:0]  start_pos;
        logic [TIME_W-1:0] release_stamp;
    } track_t;

    typedef struct packed {
        logic [POS_W-1:0]  grab_pos;
        logic              should_yield;
        logic              is_moving;
        logic              is_touched;
        logic              phase_changed;
        logic [CODE_W-1:0] touch_phase;
    } result_t;

    function automatic logic [CODE_W-1:0] phase_code(input phase_t ph);
        logic [CODE_W-1:0] code;
        case (ph)
            PH_IDLE:     code = CODE_IDLE;
            PH_TOUCHED:  code = CODE_TOUCHED;
            PH_MOVING:   code = CODE_MOVING;
            PH_RELEASED: code = CODE_RELEASED;
            default:     code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/fty_step.sv @@
// ----------------------------------------------------------------------------
// fty_step
// one-sample update of the touch machine, force run and yield decision
// ----------------------------------------------------------------------------
module fty_step
    import fty_pkg::*;
(
    input  cfg_t    cfg,
    input  sample_t smp,
    input  track_t  cur,
    output track_t  nxt,
    output result_t res
);

    logic              touch;
    logic              high;
    logic [POS_W-1:0]  pos_step;
    logic [TIME_W-1:0] elapsed;
    logic              touched;

    always_comb
    begin
        touch    = smp.touch_sample > cfg.touch_level;
        high     = smp.current_sample > cfg.current_level;
        pos_step = (smp.fader_pos >= cur.prev_pos) ? (smp.fader_pos - cur.prev_pos)
                                                   : (cur.prev_pos - smp.fader_pos);
        elapsed  = smp.now_ms - cur.release_stamp;

        nxt          = cur;
        nxt.prev_pos = smp.fader_pos;

        if (!high)
        begin
            nxt.high_run = '0;
        end
        else if (cur.high_run != RUN_MAX)
        begin
            nxt.high_run = cur.high_run + RUN_W'(1);
        end

        case (cur.phase)
            PH_IDLE:
            begin
                if (touch)
                begin
                    nxt.start_pos = smp.fader_pos;
                    nxt.phase     = PH_TOUCHED;
                end
            end
            PH_TOUCHED:
            begin
                if (!touch)
                begin
                    nxt.release_stamp = smp.now_ms;
                    nxt.phase         = PH_RELEASED;
                end
                else if (pos_step > cfg.move_level)
                begin
                    nxt.phase = PH_MOVING;
                end
            end
            PH_MOVING:
            begin
                if (!touch)
                begin
                    nxt.release_stamp = smp.now_ms;
                    nxt.phase         = PH_RELEASED;
                end
            end
            default:
            begin
                if (touch)
                begin
                    nxt.phase = PH_TOUCHED;
                end
                else if (elapsed > TIME_W'(cfg.debounce_time))
                begin
                    nxt.phase = PH_IDLE;
                end
            end
        endcase

        touched = (nxt.phase == PH_TOUCHED) || (nxt.phase == PH_MOVING);

        res.touch_phase   = phase_code(nxt.phase);
        res.phase_changed = nxt.phase != cur.phase;
        res.is_touched    = touched;
        res.is_moving     = nxt.phase == PH_MOVING;
        res.grab_pos      = nxt.start_pos;
        case (cfg.feedback_mode)
            MODE_DISABLED: res.should_yield = 1'b0;
            MODE_FOLLOW:   res.should_yield = touched;
            default:       res.should_yield = nxt.high_run >= cfg.force_samples;
        endcase
    end

endmodule

@@ rtl/fader_touch_yield_detector_core.sv @@
// ----------------------------------------------------------------------------
// fader_touch_yield_detector_core
// touch phase tracking and force-feedback yield decision for a motor fader
// ----------------------------------------------------------------------------
// Each input request carries one touch sample, one motor-current sample, the
// fader position (Q0.12 of travel) and a millisecond timestamp, and produces
// exactly one result request. A request is taken into an input register, the
// whole update of the touch machine (idle, touched, moving, released) and of
// the saturating high-current run is one short combinational pass, and the
// result lands in an output register. The result becomes valid when the
// sample moves from the input register into the output register; one
// request is accepted every cycle as long as the output side keeps taking
// results, set by the single update pass per sample. The released phase
// returns to idle once the modular 32-bit time since release exceeds
// debounce_time. Configuration writes go through cfg_wen, cfg_index and
// cfg_wdata and should only be issued while no request is in flight;
// writes to indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module fader_touch_yield_detector_core
    import fty_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // sample requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // touch_sample[11:0], current_sample[23:12], fader_pos[35:24],
    // now_ms[67:36], zero fill[71:68]
    input  logic [71:0]           s_tdata,
    // result requests
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // touch_phase[1:0], phase_changed[2], is_touched[3], is_moving[4],
    // should_yield[5], grab_pos[17:6], zero fill[23:18]
    output logic [23:0]           m_tdata
);

    localparam int unsigned RES_W = $bits(result_t);

    cfg_t    cfg_reg;
    track_t  track_reg;
    track_t  track_next;
    result_t step_res;

    logic    in_valid_reg;
    sample_t in_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;

    logic    out_load;
    logic    in_load;

    // output register frees up when empty or being drained this cycle
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    // input register frees up when empty or moving forward this cycle
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    // configuration registers, unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.touch_level   <= RST_TOUCH_LEVEL;
            cfg_reg.current_level <= RST_CURRENT_LEVEL;
            cfg_reg.feedback_mode <= RST_FEEDBACK_MODE;
            cfg_reg.move_level    <= RST_MOVE_LEVEL;
            cfg_reg.debounce_time <= RST_DEBOUNCE_TIME;
            cfg_reg.force_samples <= RST_FORCE_SAMPLES;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_TOUCH_LEVEL:   cfg_reg.touch_level   <= cfg_wdata[ADC_W-1:0];
                REG_CURRENT_LEVEL: cfg_reg.current_level <= cfg_wdata[ADC_W-1:0];
                REG_FEEDBACK_MODE: cfg_reg.feedback_mode <= cfg_wdata[MODE_W-1:0];
                REG_MOVE_LEVEL:    cfg_reg.move_level    <= cfg_wdata[POS_W-1:0];
                REG_DEBOUNCE_TIME: cfg_reg.debounce_time <= cfg_wdata[DEB_W-1:0];
                REG_FORCE_SAMPLES: cfg_reg.force_samples <= cfg_wdata[RUN_W-1:0];
                default:           ;
            endcase
        end
    end

    // input stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input stage payload, extra bits above each field are dropped here
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg.touch_sample   <= s_tdata[11:0];
            in_data_reg.current_sample <= s_tdata[23:12];
            in_data_reg.fader_pos      <= s_tdata[35:24];
            in_data_reg.now_ms         <= s_tdata[67:36];
        end
    end

    // single pass update of the detector state
    fty_step u_step (
        .cfg (cfg_reg),
        .smp (in_data_reg),
        .cur (track_reg),
        .nxt (track_next),
        .res (step_res)
    );

    // tracked state advances only when the sample moves into the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg.phase         <= PH_IDLE;
            track_reg.high_run      <= '0;
            track_reg.prev_pos      <= '0;
            track_reg.start_pos     <= '0;
            track_reg.release_stamp <= '0;
        end
        else if (out_load)
        begin
            track_reg <= track_next;
        end
    end

    // result stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(24 - RES_W)'(0), out_data_reg};

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // moving is a touched phase
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[3])
        else $error("moving result without touched flag");

    // touched flag agrees with the reported phase code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3] == ((m_tdata[1:0] == CODE_TOUCHED) ||
                                     (m_tdata[1:0] == CODE_MOVING))))
        else $error("touched flag disagrees with phase");

    // high-current run holds at its ceiling instead of wrapping
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (track_reg.high_run == RUN_MAX) &&
        (in_data_reg.current_sample > cfg_reg.current_level)
        |=> track_reg.high_run == RUN_MAX)
        else $error("high-current run wrapped");

    // the tracked state only moves when a sample is delivered into the result
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_load |=> $stable(track_reg))
        else $error("state changed without a sample");

endmodule
